/* rtl/core/cvp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cvp_pkg;

  localparam logic [1:0] KIND_BINARY = 2'd0;
  localparam logic [1:0] KIND_UNARY  = 2'd1;
  localparam logic [1:0] KIND_TOKEN  = 2'd2;

  localparam logic [1:0] REG_NONTERMINALS = 2'd0;
  localparam logic [1:0] REG_VOCABULARY   = 2'd1;
  localparam logic [1:0] REG_LENGTH       = 2'd2;

  localparam logic signed [31:0] NO_PARSE_SCORE = -32'sd1000000000;
  localparam logic signed [31:0] SKIP_LIMIT     = -32'sd500000000;
  localparam logic signed [33:0] SUM_MAX        = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN        = -34'sd2147483648;

  typedef struct packed {
    logic [4:0]  nonterminal_count;
    logic [10:0] vocabulary_size;
    logic [5:0]  sentence_length;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOK_RD,
    ST_TOK_WAIT,
    ST_UNI_RD,
    ST_UNI_WAIT,
    ST_CELL_INIT,
    ST_LEFT_RD,
    ST_LEFT_WAIT,
    ST_RIGHT_RD,
    ST_RIGHT_WAIT,
    ST_CELL_WR,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_OUT
  } seq_state_t;

endpackage
`default_nettype wire

/* rtl/core/cvp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cvp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         parent_symbol;
  logic [3:0]         left_symbol;
  logic [3:0]         right_symbol;
  logic [9:0]         word_id;
  logic signed [31:0] score_value;

  modport source (output valid, kind, parent_symbol, left_symbol, right_symbol, word_id,
                  score_value, input ready);
  modport sink (input valid, kind, parent_symbol, left_symbol, right_symbol, word_id,
                score_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/cvp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] parse_score;
  logic               saturated;

  modport source (output valid, parse_score, saturated, input ready);
  modport sink (input valid, parse_score, saturated, output ready);
endinterface
`default_nettype wire

/* rtl/core/cvp_apb_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module cvp_apb_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cvp_pkg::cfg_regs_t     cfg
);

  logic [1:0] reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nonterminal_count <= 5'd16;
      cfg.vocabulary_size   <= 11'd1024;
      cfg.sentence_length   <= 6'd32;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        cvp_pkg::REG_NONTERMINALS: cfg.nonterminal_count <= pwdata[4:0];
        cvp_pkg::REG_VOCABULARY:   cfg.vocabulary_size   <= pwdata[10:0];
        cvp_pkg::REG_LENGTH:       cfg.sentence_length   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cvp_pkg::REG_NONTERMINALS: prdata = {27'd0, cfg.nonterminal_count};
      cvp_pkg::REG_VOCABULARY:   prdata = {21'd0, cfg.vocabulary_size};
      cvp_pkg::REG_LENGTH:       prdata = {26'd0, cfg.sentence_length};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/cvp_score_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module cvp_score_unit (
  input  wire logic signed [31:0] rule_score,
  input  wire logic signed [31:0] left_score,
  input  wire logic signed [31:0] right_score,
  input  wire logic signed [31:0] best_in,
  output logic signed [31:0]      best_out,
  output logic                    clipped
);

  logic signed [33:0] sum;
  logic signed [31:0] cand;

  assign sum = 34'(rule_score) + 34'(left_score) + 34'(right_score);

  always_comb begin
    clipped = 1'b0;
    cand    = sum[31:0];
    if (sum > cvp_pkg::SUM_MAX) begin
      clipped = 1'b1;
      cand    = 32'sh7fffffff;
    end else if (sum < cvp_pkg::SUM_MIN) begin
      clipped = 1'b1;
      cand    = 32'sh80000000;
    end
    best_out = (cand > best_in) ? cand : best_in;
  end

endmodule
`default_nettype wire

/* rtl/core/cyk_viterbi_parse_score_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// max-sum cyk parse score engine
// in_ch carries table writes and tokens: kind 0 stores a binary rule score, kind 1 a unary
// word score, kind 2 appends a token; kind 3 is dropped. table and token requests are
// taken only while the engine is idle. the request carrying the last token of a sentence
// starts the chart fill, during which in_ch.ready stays low.
// fill order, all with one shared saturating adder:
//   the length-one spans first, each token read and then one unary score per symbol;
//   then per cell and symbol, every split and left child, and every right child of a
//   left child above the skip limit, then the cell write; last the start symbol is read out.
// out_ch gets one request per sentence: parse_score and saturated. it is held in an output
// register until taken; a stalled receiver only holds the engine at its last step.
// configuration is on the apb port, registers at byte 0, 4, 8.
// reset clears the token count, the sequencer and the output register; the score tables
// and the chart are not cleared and must be written before they are used.
module cyk_viterbi_parse_score_core #(
  parameter int MAX_SYMBOLS = 16,
  parameter int MAX_WORDS   = 1024,
  parameter int MAX_TOKENS  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cvp_in_if.sink     in_ch,
  cvp_out_if.source  out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int WW = $clog2(MAX_WORDS);
  localparam int JW = $clog2(MAX_TOKENS + 1);
  localparam int TW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int CW = 2 * JW + SW;

  cvp_pkg::cfg_regs_t  cfg;
  cvp_pkg::seq_state_t state, state_next;

  logic signed [31:0] rule_mem  [2**(3*SW)];
  logic signed [31:0] uni_mem   [2**(SW+WW)];
  logic [9:0]         tok_mem   [2**TW];
  logic signed [31:0] chart_mem [2**CW];

  logic signed [31:0] rule_rd, uni_rd, chart_rd_a, chart_rd_b;
  logic [9:0]         tok_rd;
  logic [9:0]         word_q;
  logic signed [31:0] left_q, best, best_cand, result;
  logic               clip, clip_cand, out_valid, out_sat;
  logic [JW-1:0]      tok_cnt, len_eff, pos_i, pos_k, span, pos_j;
  logic [SW-1:0]      sym_a, sym_l, sym_r, n_last;
  logic [31:0]        n_raw, v_raw, len_raw, n_eff, v_eff;
  logic               in_acc, tok_done, last_a, last_l, last_r;

  logic [CW-1:0]      chart_wa, chart_ra_a, chart_ra_b;
  logic               chart_we;
  logic signed [31:0] chart_wd;

  cvp_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cvp_score_unit u_score (
    .rule_score(rule_rd), .left_score(left_q), .right_score(chart_rd_b),
    .best_in(best), .best_out(best_cand), .clipped(clip_cand)
  );

  // effective register values, clamped into 1..bound
  assign n_raw   = 32'(cfg.nonterminal_count);
  assign v_raw   = 32'(cfg.vocabulary_size);
  assign len_raw = 32'(cfg.sentence_length);
  assign n_eff   = (n_raw == 0) ? 32'd1 : ((n_raw > MAX_SYMBOLS) ? 32'(MAX_SYMBOLS) : n_raw);
  assign v_eff   = (v_raw == 0) ? 32'd1 : ((v_raw > MAX_WORDS) ? 32'(MAX_WORDS) : v_raw);
  assign len_eff = (len_raw == 0) ? JW'(1) :
                   ((len_raw > MAX_TOKENS) ? JW'(MAX_TOKENS) : len_raw[JW-1:0]);
  assign n_last  = SW'(n_eff - 32'd1);

  assign last_a = (sym_a == n_last);
  assign last_l = (sym_l == n_last);
  assign last_r = (sym_r == n_last);
  assign pos_j  = pos_i + span;

  assign in_ch.ready = (state == cvp_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tok_done    = in_acc && (in_ch.kind == cvp_pkg::KIND_TOKEN) &&
                       (32'(tok_cnt) + 32'd1 >= 32'(len_eff));

  assign out_ch.valid       = out_valid;
  assign out_ch.parse_score = result;
  assign out_ch.saturated   = out_sat;

  // table and token writes
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.kind == cvp_pkg::KIND_BINARY && 32'(in_ch.parent_symbol) < MAX_SYMBOLS
        && 32'(in_ch.left_symbol) < MAX_SYMBOLS && 32'(in_ch.right_symbol) < MAX_SYMBOLS) begin
      rule_mem[{SW'(in_ch.parent_symbol), SW'(in_ch.left_symbol), SW'(in_ch.right_symbol)}]
        <= in_ch.score_value;
    end
    if (in_acc && in_ch.kind == cvp_pkg::KIND_UNARY && 32'(in_ch.parent_symbol) < MAX_SYMBOLS
        && 32'(in_ch.word_id) < MAX_WORDS) begin
      uni_mem[{SW'(in_ch.parent_symbol), WW'(in_ch.word_id)}] <= in_ch.score_value;
    end
    if (in_acc && in_ch.kind == cvp_pkg::KIND_TOKEN) begin
      tok_mem[TW'(tok_cnt)] <= in_ch.word_id;
    end
  end

  // memory reads, data registered
  always_ff @(posedge clk) begin
    tok_rd     <= tok_mem[TW'(pos_i)];
    uni_rd     <= uni_mem[{sym_a, WW'(word_q)}];
    rule_rd    <= rule_mem[{sym_a, sym_l, sym_r}];
    chart_rd_a <= chart_mem[chart_ra_a];
    chart_rd_b <= chart_mem[chart_ra_b];
    if (chart_we) begin
      chart_mem[chart_wa] <= chart_wd;
    end
  end

  always_comb begin
    chart_ra_a = {pos_i, pos_k, sym_l};
    chart_ra_b = {pos_k, pos_j, sym_r};
    if (state == cvp_pkg::ST_FIN_RD || state == cvp_pkg::ST_FIN_WAIT ||
        state == cvp_pkg::ST_OUT) begin
      chart_ra_a = {JW'(0), len_eff, SW'(0)};
    end
    chart_we = 1'b0;
    chart_wa = {pos_i, pos_j, sym_a};
    chart_wd = best;
    if (state == cvp_pkg::ST_UNI_WAIT) begin
      chart_we = 1'b1;
      chart_wa = {pos_i, pos_i + JW'(1), sym_a};
      chart_wd = (32'(word_q) < v_eff) ? uni_rd : cvp_pkg::NO_PARSE_SCORE;
    end else if (state == cvp_pkg::ST_CELL_WR) begin
      chart_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cvp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cvp_pkg::ST_IDLE:      if (tok_done) state_next = cvp_pkg::ST_TOK_RD;
      cvp_pkg::ST_TOK_RD:    state_next = cvp_pkg::ST_TOK_WAIT;
      cvp_pkg::ST_TOK_WAIT:  state_next = cvp_pkg::ST_UNI_RD;
      cvp_pkg::ST_UNI_RD:    state_next = cvp_pkg::ST_UNI_WAIT;
      cvp_pkg::ST_UNI_WAIT: begin
        if (!last_a) state_next = cvp_pkg::ST_UNI_RD;
        else if (pos_i != len_eff - JW'(1)) state_next = cvp_pkg::ST_TOK_RD;
        else if (len_eff == JW'(1)) state_next = cvp_pkg::ST_FIN_RD;
        else state_next = cvp_pkg::ST_CELL_INIT;
      end
      cvp_pkg::ST_CELL_INIT: state_next = cvp_pkg::ST_LEFT_RD;
      cvp_pkg::ST_LEFT_RD:   state_next = cvp_pkg::ST_LEFT_WAIT;
      cvp_pkg::ST_LEFT_WAIT: begin
        if (chart_rd_a > cvp_pkg::SKIP_LIMIT) state_next = cvp_pkg::ST_RIGHT_RD;
        else if (!last_l || pos_k != pos_j - JW'(1)) state_next = cvp_pkg::ST_LEFT_RD;
        else state_next = cvp_pkg::ST_CELL_WR;
      end
      cvp_pkg::ST_RIGHT_RD:  state_next = cvp_pkg::ST_RIGHT_WAIT;
      cvp_pkg::ST_RIGHT_WAIT: begin
        if (!last_r) state_next = cvp_pkg::ST_RIGHT_RD;
        else if (!last_l || pos_k != pos_j - JW'(1)) state_next = cvp_pkg::ST_LEFT_RD;
        else state_next = cvp_pkg::ST_CELL_WR;
      end
      cvp_pkg::ST_CELL_WR: begin
        if (last_a && pos_j == len_eff && span == len_eff) state_next = cvp_pkg::ST_FIN_RD;
        else state_next = cvp_pkg::ST_CELL_INIT;
      end
      cvp_pkg::ST_FIN_RD:    state_next = cvp_pkg::ST_FIN_WAIT;
      cvp_pkg::ST_FIN_WAIT:  state_next = cvp_pkg::ST_OUT;
      cvp_pkg::ST_OUT:       if (!out_valid || out_ch.ready) state_next = cvp_pkg::ST_IDLE;
      default:               state_next = cvp_pkg::ST_IDLE;
    endcase
  end

  // loop counters and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_cnt   <= '0;
      out_valid <= 1'b0;
      out_sat   <= 1'b0;
      clip      <= 1'b0;
    end else begin
      // output register is loaded only once the previous request has left
      if (state == cvp_pkg::ST_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
        result    <= chart_rd_a;
        out_sat   <= clip;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        cvp_pkg::ST_IDLE: begin
          if (in_acc && in_ch.kind == cvp_pkg::KIND_TOKEN) begin
            tok_cnt <= tok_done ? JW'(0) : tok_cnt + JW'(1);
          end
          if (tok_done) begin
            pos_i <= '0;
            clip  <= 1'b0;
          end
        end
        cvp_pkg::ST_TOK_WAIT: begin
          word_q <= tok_rd;
          sym_a  <= '0;
        end
        cvp_pkg::ST_UNI_WAIT: begin
          sym_a <= last_a ? SW'(0) : sym_a + SW'(1);
          if (last_a) begin
            pos_i <= (pos_i == len_eff - JW'(1)) ? JW'(0) : pos_i + JW'(1);
            span  <= JW'(2);
          end
        end
        cvp_pkg::ST_CELL_INIT: begin
          pos_k <= pos_i + JW'(1);
          sym_l <= '0;
          best  <= cvp_pkg::NO_PARSE_SCORE;
        end
        cvp_pkg::ST_LEFT_WAIT: begin
          left_q <= chart_rd_a;
          sym_r  <= '0;
          if (chart_rd_a <= cvp_pkg::SKIP_LIMIT) begin
            sym_l <= last_l ? SW'(0) : sym_l + SW'(1);
            if (last_l) pos_k <= pos_k + JW'(1);
          end
        end
        cvp_pkg::ST_RIGHT_WAIT: begin
          if (chart_rd_b > cvp_pkg::SKIP_LIMIT) begin
            best <= best_cand;
            if (clip_cand) clip <= 1'b1;
          end
          sym_r <= last_r ? SW'(0) : sym_r + SW'(1);
          if (last_r) begin
            sym_l <= last_l ? SW'(0) : sym_l + SW'(1);
            if (last_l) pos_k <= pos_k + JW'(1);
          end
        end
        cvp_pkg::ST_CELL_WR: begin
          sym_a <= last_a ? SW'(0) : sym_a + SW'(1);
          if (last_a) begin
            if (pos_j == len_eff) begin
              pos_i <= '0;
              span  <= span + JW'(1);
            end else begin
              pos_i <= pos_i + JW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_split_inside: assert property (@(posedge clk) disable iff (rst)
    state == cvp_pkg::ST_RIGHT_RD |-> (pos_k > pos_i) && (pos_k < pos_j))
    else $error("split point outside span");

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    state == cvp_pkg::ST_CELL_WR |-> (pos_j <= len_eff) && (span >= JW'(2)))
    else $error("chart cell beyond sentence");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == cvp_pkg::ST_OUT)
    else $error("result raised outside readout");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    tok_done |=> !in_ch.ready)
    else $error("input taken during chart fill");

endmodule
`default_nettype wire

/* bench/cvp_tb_if.sv */
`timescale 1ns / 1ps
// the block's own channel interfaces come with the rtl; this file only holds
// the bench-side score record shared by the checker and the driver
package cvp_tb_pkg;
  typedef struct {
    logic signed [31:0] score;
    logic               sat;
  } parse_result_t;
endpackage

/* bench/cyk_viterbi_parse_score_core_tb.sv */
`timescale 1ns / 1ps
module cyk_viterbi_parse_score_core_tb;
  import cvp_pkg::*;
  import cvp_tb_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int NSYM = 16;
  localparam int NWORD = 1024;
  localparam int NTOK = 32;
  localparam int SETTLE = 40;
  localparam int WORD_SET[7] = '{0, 1, 2, 3, 4, 5, 1023};

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cvp_in_if in_ch ();
  cvp_out_if out_ch ();

  cyk_viterbi_parse_score_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow state of the block
  int rule_score[NSYM*NSYM*NSYM];
  int word_score[NSYM*NWORD];
  int token_buf[NTOK];
  int token_cnt;
  int chart[NTOK][NTOK+1][NSYM];
  int nt_reg, voc_reg, len_reg;

  parse_result_t pending_scores[$];
  int errors;
  int items_sent;
  int hold_left;
  int stall_left;
  bit quiet_rx;
  bit quiet_tx;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int clamp_reg(int x, int hi);
    if (x < 1) return 1;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic parse_result_t score_sentence();
    parse_result_t res;
    int n, v, len, w, j, best, left, right;
    longint sum;
    int cand;
    n = clamp_reg(nt_reg, NSYM);
    v = clamp_reg(voc_reg, NWORD);
    len = clamp_reg(len_reg, NTOK);
    res.sat = 1'b0;
    for (int i = 0; i < len; i++) begin
      w = token_buf[i];
      for (int a = 0; a < n; a++)
        chart[i][i+1][a] = (w < v) ? word_score[a*NWORD + w] : int'(NO_PARSE_SCORE);
    end
    for (int span = 2; span <= len; span++) begin
      for (int i = 0; i + span <= len; i++) begin
        j = i + span;
        for (int a = 0; a < n; a++) begin
          best = NO_PARSE_SCORE;
          for (int k = i + 1; k < j; k++)
            for (int lb = 0; lb < n; lb++) begin
              left = chart[i][k][lb];
              if (left > int'(SKIP_LIMIT))
                for (int rc = 0; rc < n; rc++) begin
                  right = chart[k][j][rc];
                  if (right > int'(SKIP_LIMIT)) begin
                    sum = longint'(rule_score[(a*NSYM + lb)*NSYM + rc]) + left + right;
                    if (sum > 64'sd2147483647) begin
                      cand = 32'sh7fffffff;
                      res.sat = 1'b1;
                    end else if (sum < -64'sd2147483648) begin
                      cand = 32'sh80000000;
                      res.sat = 1'b1;
                    end else begin
                      cand = int'(sum);
                    end
                    if (cand > best) best = cand;
                  end
                end
            end
          chart[i][j][a] = best;
        end
      end
    end
    res.score = chart[0][len][0];
    return res;
  endfunction

  function automatic void absorb_request(logic [1:0] kind, int p, int l, int r, int w, int s);
    if (kind == KIND_BINARY) begin
      rule_score[(p*NSYM + l)*NSYM + r] = s;
    end else if (kind == KIND_UNARY) begin
      word_score[p*NWORD + w] = s;
    end else if (kind == KIND_TOKEN) begin
      if (token_cnt < NTOK) token_buf[token_cnt] = w;
      token_cnt++;
      if (token_cnt >= clamp_reg(len_reg, NTOK)) begin
        token_cnt = 0;
        pending_scores.push_back(score_sentence());
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: check, then choose ready for the next edge
  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("unexpected result", out_ch.parse_score, 0);
        end else begin
          want = pending_scores.pop_front();
          if (out_ch.parse_score !== want.score)
            report_mismatch("parse_score", out_ch.parse_score, want.score);
          if (out_ch.saturated !== want.sat)
            report_mismatch("saturated", out_ch.saturated, want.sat);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet_rx && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_request(logic [1:0] kind, int p, int l, int r, int w, int s);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.parent_symbol <= p[3:0];
    in_ch.left_symbol <= l[3:0];
    in_ch.right_symbol <= r[3:0];
    in_ch.word_id <= w[9:0];
    in_ch.score_value <= s;
    do @(posedge clk); while (!in_ch.ready);
    absorb_request(kind, p, l, r, w, s);
    if (kind != KIND_IGNORED) items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NONTERMINALS) nt_reg = value & 'h1f;
    else if (idx == REG_VOCABULARY) voc_reg = value & 'h7ff;
    else if (idx == REG_LENGTH) len_reg = value & 'h3f;
  endtask

  task automatic set_config(int n, int v, int len);
    write_reg(REG_NONTERMINALS, n);
    write_reg(REG_VOCABULARY, v);
    write_reg(REG_LENGTH, len);
  endtask

  function automatic int any_score();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return int'($urandom);
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic int dead_score();
    if ($urandom_range(0, 7) == 0) return int'(SKIP_LIMIT);
    return -int'($urandom_range(32'd500000001, 32'd2147483647));
  endfunction

  // symbols 2 and up never score above the skip limit on used words, so spans of two
  // words read only rules with children 0 and 1
  task automatic load_tables();
    for (int a = 0; a < NSYM; a++)
      for (int c = 0; c < 4; c++)
        send_request(KIND_BINARY, a, c / 2, c % 2, 0, any_score());
    for (int a = 0; a < NSYM; a++)
      for (int k = 0; k < 7; k++)
        send_request(KIND_UNARY, a, 0, 0, WORD_SET[k], (a < 2) ? any_score() : dead_score());
  endtask

  task automatic test_extremes();
    set_config(0, 1024, 1);
    send_request(KIND_UNARY, 0, 0, 0, 0, 32'sh7fffffff);
    send_request(KIND_TOKEN, 0, 0, 0, 0, 0);
    send_request(KIND_UNARY, 0, 0, 0, 1023, 32'sh80000000);
    send_request(KIND_TOKEN, 15, 15, 15, 1023, -1);
    send_request(KIND_IGNORED, 15, 15, 15, 1023, -1);
    set_config(31, 2047, 2);
    send_request(KIND_TOKEN, 0, 0, 0, 1023, 0);
    send_request(KIND_TOKEN, 0, 0, 0, 3, 0);
    // word beyond the vocabulary
    set_config(2, 0, 2);
    send_request(KIND_TOKEN, 0, 0, 0, 0, 0);
    send_request(KIND_TOKEN, 0, 0, 0, 1023, 0);
    set_config(2, 7, 63);
    for (int i = 0; i < 32; i++) send_request(KIND_TOKEN, 0, 0, 0, WORD_SET[i % 7], 0);
  endtask

  task automatic test_saturation();
    set_config(2, 1024, 2);
    send_request(KIND_UNARY, 0, 0, 0, 2, 32'sh7fffffff);
    send_request(KIND_UNARY, 1, 0, 0, 2, 32'sh7fffffff);
    send_request(KIND_BINARY, 0, 1, 1, 0, 32'sh7fffffff);
    send_request(KIND_TOKEN, 0, 0, 0, 2, 0);
    send_request(KIND_TOKEN, 0, 0, 0, 2, 0);
    send_request(KIND_UNARY, 0, 0, 0, 3, -400000000);
    send_request(KIND_UNARY, 1, 0, 0, 3, -400000000);
    send_request(KIND_BINARY, 0, 0, 0, 0, 32'sh80000000);
    send_request(KIND_BINARY, 0, 0, 1, 0, 32'sh80000000);
    send_request(KIND_BINARY, 0, 1, 0, 0, 32'sh80000000);
    send_request(KIND_BINARY, 0, 1, 1, 0, 32'sh80000000);
    send_request(KIND_TOKEN, 0, 0, 0, 3, 0);
    send_request(KIND_TOKEN, 0, 0, 0, 3, 0);
  endtask

  task automatic test_length_lowered();
    set_config(2, 1024, 6);
    for (int i = 0; i < 4; i++) send_request(KIND_TOKEN, 0, 0, 0, WORD_SET[i], 0);
    write_reg(REG_LENGTH, 2);
    send_request(KIND_TOKEN, 0, 0, 0, 5, 0);
  endtask

  task automatic test_backpressure();
    set_config(1, 1024, 1);
    quiet_tx = 1'b1;
    hold_left = 400;
    for (int i = 0; i < 8; i++) send_request(KIND_TOKEN, 0, 0, 0, WORD_SET[i % 7], 0);
    quiet_tx = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int n, v, len, veff, sel, w, p;
    while (items_sent < 750) begin
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(0, 2);
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 63) : $urandom_range(0, 7);
      end else begin
        n = $urandom_range(3, 31);
        len = $urandom_range(0, 2);
      end
      case ($urandom_range(0, 4))
        0: v = 1024;
        1: v = 2047;
        2: v = $urandom_range(0, 7);
        default: v = $urandom_range(0, 1023);
      endcase
      quiet_rx = ($urandom_range(0, 5) == 0);
      quiet_tx = ($urandom_range(0, 5) == 0);
      set_config(n, v, len);
      veff = clamp_reg(voc_reg, NWORD);
      for (int i = 0; i < 30; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          if (veff < NWORD && $urandom_range(0, 3) == 0) w = $urandom_range(veff, 1023);
          else w = WORD_SET[$urandom_range(0, 6)];
          send_request(KIND_TOKEN, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), w, int'($urandom));
        end else if (sel < 75) begin
          send_request(KIND_BINARY, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 1023), any_score());
        end else if (sel < 95) begin
          p = $urandom_range(0, 15);
          if ($urandom_range(0, 2) == 0) begin
            w = $urandom_range(0, 1023);
            foreach (WORD_SET[k]) if (WORD_SET[k] == w) w = 6;
          end else begin
            w = WORD_SET[$urandom_range(0, 6)];
          end
          send_request(KIND_UNARY, p, $urandom_range(0, 15), $urandom_range(0, 15), w,
                       (p >= 2 && (w < 6 || w == 1023)) ? dead_score() : any_score());
        end else begin
          send_request(KIND_IGNORED, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 1023), int'($urandom));
        end
      end
    end
    quiet_rx = 1'b0;
    quiet_tx = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_IGNORED;
    in_ch.parent_symbol = '0;
    in_ch.left_symbol = '0;
    in_ch.right_symbol = '0;
    in_ch.word_id = '0;
    in_ch.score_value = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    items_sent = 0;
    hold_left = 0;
    stall_left = 0;
    quiet_rx = 1'b0;
    quiet_tx = 1'b0;
    token_cnt = 0;
    nt_reg = 16;
    voc_reg = 1024;
    len_reg = 32;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tables();
    test_extremes();
    load_tables();
    test_saturation();
    test_length_lowered();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/cvp_pkg.sv
rtl/core/cvp_in_if.sv
rtl/core/cvp_out_if.sv
rtl/core/cvp_apb_regs.sv
rtl/core/cvp_score_unit.sv
rtl/core/cyk_viterbi_parse_score_core.sv
bench/cvp_tb_if.sv
bench/cyk_viterbi_parse_score_core_tb.sv
